// File: design/dcq_pkg.sv
// shared types, constants and helper functions for the dct coefficient quantizer
package dcq_pkg;

  // field widths
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned WT_W    = 8;
  localparam int unsigned SCALE_W = 10;

  // weight matrix geometry
  localparam int unsigned BLOCK_COEFFS = 64;
  localparam int unsigned NUM_MATRICES = 2;
  localparam int unsigned TBL_DEPTH    = NUM_MATRICES * BLOCK_COEFFS;
  localparam int unsigned TBL_AW       = $clog2(TBL_DEPTH);

  // divider widths: numerator is |coefficient| * 4, divisor is weight * scale
  localparam int unsigned NUM_W = COEFF_W + 2;
  localparam int unsigned DIV_W = WT_W + SCALE_W;
  localparam int unsigned Q_W   = NUM_W;

  // request type codes
  localparam logic REQ_QUANT = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // side information that travels with a coefficient through the divider
  typedef struct packed {
    logic             neg;
    logic             div_zero;
    logic [POS_W-1:0] pos;
    logic             eos;
  } meta_t;

  // one divider pipeline stage
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   quo;
    logic [DIV_W-1:0] dvs;
    meta_t            meta;
  } div_stage_t;

  // one finished result
  typedef struct packed {
    logic signed [COEFF_W-1:0] quantized;
    logic [POS_W-1:0]          pos;
    logic                      eos;
  } res_t;

  // table address from matrix number and block position, both wrapped
  function automatic logic [TBL_AW-1:0] tbl_index(logic sel, logic [POS_W-1:0] pos);
    int unsigned m;
    int unsigned p;
    m = int'(sel) % NUM_MATRICES;
    p = int'(pos) % BLOCK_COEFFS;
    return TBL_AW'(m * BLOCK_COEFFS + p);
  endfunction

  // one restoring division step: bring down the numerator msb, try a subtract
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t         r;
    logic [DIV_W:0]     part;
    logic [DIV_W:0]     diff;
    r    = s;
    part = {s.rem, s.num[NUM_W-1]};
    diff = part - {1'b0, s.dvs};
    r.num = {s.num[NUM_W-2:0], 1'b0};
    if (part >= {1'b0, s.dvs}) begin
      r.rem = diff[DIV_W-1:0];
      r.quo = {s.quo[Q_W-2:0], 1'b1};
    end else begin
      r.rem = part[DIV_W-1:0];
      r.quo = {s.quo[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: design/dcq_in_if.sv
// request channel: coefficients to quantize and weight loads
interface dcq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic                               matrix_sel;
  logic [dcq_pkg::POS_W-1:0]          coeff_position;
  logic signed [dcq_pkg::COEFF_W-1:0] coefficient;
  logic [dcq_pkg::WT_W-1:0]           weight_value;
  logic                               end_of_slice;

  modport source (
    output valid, req_type, matrix_sel, coeff_position, coefficient, weight_value,
           end_of_slice,
    input  ready
  );
  modport sink (
    input  valid, req_type, matrix_sel, coeff_position, coefficient, weight_value,
           end_of_slice,
    output ready
  );
endinterface

// File: design/dcq_out_if.sv
// result channel: quantized coefficients
interface dcq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dcq_pkg::COEFF_W-1:0] quantized;
  logic [dcq_pkg::POS_W-1:0]          position_out;
  logic                               end_of_slice_out;

  modport source (
    output valid, quantized, position_out, end_of_slice_out,
    input  ready
  );
  modport sink (
    input  valid, quantized, position_out, end_of_slice_out,
    output ready
  );
endinterface

// File: design/dcq_ram.sv
// generic single-write, single-read ram with registered read data
module dcq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/dcq_div.sv
// pipelined restoring divider, one quotient bit per stage
module dcq_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  dcq_pkg::div_stage_t stage_i,
  output logic                vld_o,
  output dcq_pkg::div_stage_t stage_o
);

  localparam int unsigned NSTG = dcq_pkg::Q_W;

  dcq_pkg::div_stage_t st_q [NSTG];
  dcq_pkg::div_stage_t st_d [NSTG];
  logic [NSTG-1:0]     vld_q;

  // each stage works on the previous stage's register
  always_comb begin
    st_d[0] = dcq_pkg::div_step(stage_i);
    for (int k = 1; k < NSTG; k++) begin
      st_d[k] = dcq_pkg::div_step(st_q[k-1]);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NSTG; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign vld_o   = vld_q[NSTG-1];
  assign stage_o = st_q[NSTG-1];

endmodule

// File: design/dct_coefficient_quantizer_unit.sv
// top level of the dct coefficient quantizer
// Quantizes one signed coefficient per cycle, unless the output buffer is full, as
// (coefficient * 4) / (weight * quant_scale), truncated toward zero and wrapped to 16 bits,
// with the weight read from a 128-entry luma/chroma matrix ram. Load transactions write
// one weight and give no result. A new request transaction is taken every cycle while the
// output buffer has room; the pipeline has one ram read, one multiply, 18 divider stages
// and one output register. A two-entry output buffer lets the pipeline keep moving while
// a result waits; the pipeline stalls only when both entries are full. The user must write
// quant_scale through quant_scale_we_i only while no transaction is in flight; the block
// does not enforce this. Weights are undefined until loaded.
module dct_coefficient_quantizer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          quant_scale_we_i,
  input  logic [dcq_pkg::SCALE_W-1:0]   quant_scale_i,
  dcq_in_if.sink                        req_i,
  dcq_out_if.source                     rsp_o
);

  logic [dcq_pkg::SCALE_W-1:0] scale_q;

  logic                        adv;
  logic                        req_acc;
  logic                        tbl_we;
  logic [dcq_pkg::TBL_AW-1:0]  tbl_addr;
  logic [dcq_pkg::WT_W-1:0]    tbl_rdata;

  logic                               s1_vld_q;
  logic signed [dcq_pkg::COEFF_W-1:0] s1_coeff_q;
  logic [dcq_pkg::POS_W-1:0]          s1_pos_q;
  logic                               s1_eos_q;

  logic [dcq_pkg::COEFF_W:0]   c_ext;
  logic [dcq_pkg::COEFF_W:0]   c_mag;
  dcq_pkg::div_stage_t         s2_d;
  dcq_pkg::div_stage_t         s2_q;
  logic                        s2_vld_q;

  logic                        dv_vld;
  dcq_pkg::div_stage_t         dv_out;
  logic [dcq_pkg::Q_W-1:0]     q_signed;
  dcq_pkg::res_t               res;

  logic [1:0]                  ob_cnt_q;
  dcq_pkg::res_t               head_q;
  dcq_pkg::res_t               skid_q;
  logic                        push;
  logic                        pop;

  // quantizer scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= dcq_pkg::SCALE_W'(1);
    end else if (quant_scale_we_i) begin
      scale_q <= quant_scale_i;
    end
  end

  // pipeline moves unless the output buffer is full
  assign adv         = (ob_cnt_q != 2'd2);
  assign req_i.ready = adv;
  assign req_acc     = req_i.valid && adv;
  assign tbl_we      = req_acc && (req_i.req_type == dcq_pkg::REQ_LOAD);
  assign tbl_addr    = dcq_pkg::tbl_index(req_i.matrix_sel, req_i.coeff_position);

  // weight matrix storage
  dcq_ram #(
    .WIDTH (dcq_pkg::WT_W),
    .DEPTH (dcq_pkg::TBL_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_addr),
    .wdata_i (req_i.weight_value),
    .re_i    (adv),
    .raddr_i (tbl_addr),
    .rdata_o (tbl_rdata)
  );

  // stage 1: coefficient waits for the weight read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= req_acc && (req_i.req_type == dcq_pkg::REQ_QUANT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_coeff_q <= req_i.coefficient;
      s1_pos_q   <= req_i.coeff_position;
      s1_eos_q   <= req_i.end_of_slice;
    end
  end

  // stage 2: divisor product and numerator magnitude
  always_comb begin
    c_ext = {s1_coeff_q[dcq_pkg::COEFF_W-1], s1_coeff_q};
    c_mag = s1_coeff_q[dcq_pkg::COEFF_W-1] ? (~c_ext + 1'b1) : c_ext;
    s2_d               = '0;
    s2_d.num           = {c_mag[dcq_pkg::COEFF_W-1:0], 2'b00};
    s2_d.dvs           = dcq_pkg::DIV_W'(tbl_rdata) * dcq_pkg::DIV_W'(scale_q);
    s2_d.meta.neg      = s1_coeff_q[dcq_pkg::COEFF_W-1];
    s2_d.meta.div_zero = (tbl_rdata == '0) || (scale_q == '0);
    s2_d.meta.pos      = s1_pos_q;
    s2_d.meta.eos      = s1_eos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s2_d;
    end
  end

  // divider pipeline
  dcq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (s2_vld_q),
    .stage_i (s2_q),
    .vld_o   (dv_vld),
    .stage_o (dv_out)
  );

  // sign fix, wrap and zero-divisor override
  always_comb begin
    q_signed = dv_out.meta.neg ? (~dv_out.quo + 1'b1) : dv_out.quo;
    res.quantized = dv_out.meta.div_zero ? '0 : q_signed[dcq_pkg::COEFF_W-1:0];
    res.pos       = dv_out.meta.pos;
    res.eos       = dv_out.meta.eos;
  end

  // two-entry output buffer
  assign push = adv && dv_vld;
  assign pop  = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else begin
      ob_cnt_q <= ob_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_cnt_q == 2'd2) begin
      if (pop) begin
        head_q <= skid_q;
      end
    end else if (ob_cnt_q == 2'd1) begin
      if (push && pop) begin
        head_q <= res;
      end else if (push) begin
        skid_q <= res;
      end
    end else begin
      if (push) begin
        head_q <= res;
      end
    end
  end

  assign rsp_o.valid            = (ob_cnt_q != 2'd0);
  assign rsp_o.quantized        = head_q.quantized;
  assign rsp_o.position_out     = head_q.pos;
  assign rsp_o.end_of_slice_out = head_q.eos;

endmodule

// File: sim/tb_top.sv
// testbench for dct_coefficient_quantizer_unit: random and directed traffic checked by a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one pending request transaction
  typedef struct {
    logic                               req_type;
    logic                               matrix_sel;
    logic [dcq_pkg::POS_W-1:0]          pos;
    logic signed [dcq_pkg::COEFF_W-1:0] coeff;
    logic [dcq_pkg::WT_W-1:0]           weight;
    logic                               eos;
  } req_item_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;

  logic clk;
  logic rst_n;
  logic scale_we;
  logic [dcq_pkg::SCALE_W-1:0] scale_val;

  dcq_in_if  req_if ();
  dcq_out_if rsp_if ();

  dct_coefficient_quantizer_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .quant_scale_we_i (scale_we),
    .quant_scale_i    (scale_val),
    .req_i            (req_if.sink),
    .rsp_o            (rsp_if.source)
  );

  // predictor state: weight matrices and current scale
  logic [dcq_pkg::WT_W-1:0]    weight_tab [dcq_pkg::NUM_MATRICES][dcq_pkg::BLOCK_COEFFS];
  logic [dcq_pkg::SCALE_W-1:0] scale_now = 1;

  req_item_t     req_queue[$];
  dcq_pkg::res_t expected_results[$];

  int  errors = 0;
  int  accepted = 0;
  int  loads_taken = 0;
  int  results_checked = 0;
  int  idle_cycles = 0;
  bit  req_taken = 0;
  int  req_gap = 0;
  int  rsp_stall = 0;
  int  gap_pct = 0;
  int  stall_pct = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result of one quantize transaction
  function automatic dcq_pkg::res_t quantized_of(logic sel, logic [dcq_pkg::POS_W-1:0] pos,
                                                 logic signed [dcq_pkg::COEFF_W-1:0] c,
                                                 logic e);
    int            num;
    int            dvs;
    dcq_pkg::res_t r;
    num = int'(c) * 4;
    dvs = int'(weight_tab[int'(sel) % dcq_pkg::NUM_MATRICES]
                         [int'(pos) % dcq_pkg::BLOCK_COEFFS]) * int'(scale_now);
    r.quantized = (dvs == 0) ? '0 : dcq_pkg::COEFF_W'(num / dvs);
    r.pos = pos;
    r.eos = e;
    return r;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void add_load(logic sel, logic [dcq_pkg::POS_W-1:0] pos,
                                   logic [dcq_pkg::WT_W-1:0] w);
    req_item_t it;
    it.req_type = dcq_pkg::REQ_LOAD;
    it.matrix_sel = sel;
    it.pos = pos;
    it.coeff = dcq_pkg::COEFF_W'($urandom);
    it.weight = w;
    it.eos = 1'($urandom);
    req_queue.push_back(it);
  endfunction

  function automatic void add_quant(logic sel, logic [dcq_pkg::POS_W-1:0] pos,
                                    logic signed [dcq_pkg::COEFF_W-1:0] c, logic e);
    req_item_t it;
    it.req_type = dcq_pkg::REQ_QUANT;
    it.matrix_sel = sel;
    it.pos = pos;
    it.coeff = c;
    it.weight = dcq_pkg::WT_W'($urandom);
    it.eos = e;
    req_queue.push_back(it);
  endfunction

  // weights: mostly nonzero, a zero now and then for the zero divisor path
  function automatic logic [dcq_pkg::WT_W-1:0] rand_weight();
    return ($urandom_range(0, 40) == 0) ? '0 : dcq_pkg::WT_W'($urandom_range(1, 255));
  endfunction

  // coefficients: extremes, full range, and small values typical of real blocks
  function automatic logic signed [dcq_pkg::COEFF_W-1:0] rand_coeff();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return -16'sd1;
        3: return 16'sd0;
        default: return 16'sd1;
      endcase
    end else if (r <= 3) begin
      return dcq_pkg::COEFF_W'($urandom);
    end
    return dcq_pkg::COEFF_W'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  // random traffic: mostly coefficient runs ending in an end-of-slice mark,
  // with weight reloads in between and some stray single transactions
  function automatic void add_random_traffic(int n);
    int cnt;
    int len;
    int start;
    int k;
    logic sel;
    logic [dcq_pkg::POS_W-1:0] p;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 7) begin
        sel = 1'($urandom);
        if ($urandom_range(0, 9) < 3) begin
          repeat ($urandom_range(1, 4)) begin
            p = dcq_pkg::POS_W'($urandom);
            add_load(sel, p, rand_weight());
            cnt++;
            // read right behind the write to the same entry
            if ($urandom_range(0, 1) == 1) begin
              add_quant(sel, p, rand_coeff(), 1'b0);
              cnt++;
            end
          end
        end
        len = $urandom_range(4, dcq_pkg::BLOCK_COEFFS);
        start = $urandom_range(0, dcq_pkg::BLOCK_COEFFS - 1);
        for (k = 0; k < len; k++) begin
          add_quant(sel, dcq_pkg::POS_W'((start + k) % dcq_pkg::BLOCK_COEFFS),
                    rand_coeff(), k == len - 1);
        end
        cnt += len;
      end else begin
        if ($urandom_range(0, 1) == 1)
          add_load(1'($urandom), dcq_pkg::POS_W'($urandom), rand_weight());
        else
          add_quant(1'($urandom), dcq_pkg::POS_W'($urandom), rand_coeff(), 1'($urandom));
        cnt++;
      end
    end
  endfunction

  // request driver
  always @(negedge clk) begin
    req_item_t it;
    if (rst_n && (!req_if.valid || req_taken)) begin
      if (req_gap > 0) begin
        req_if.valid <= 1'b0;
        req_gap--;
      end else if (req_queue.size() > 0 && gap_pct > 0 &&
                   $urandom_range(0, 99) < gap_pct) begin
        req_if.valid <= 1'b0;
        req_gap = $urandom_range(1, 18) - 1;
      end else if (req_queue.size() > 0) begin
        it = req_queue.pop_front();
        req_if.valid <= 1'b1;
        req_if.req_type <= it.req_type;
        req_if.matrix_sel <= it.matrix_sel;
        req_if.coeff_position <= it.pos;
        req_if.coefficient <= it.coeff;
        req_if.weight_value <= it.weight;
        req_if.end_of_slice <= it.eos;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (rsp_stall > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_if.ready <= 1'b0;
        rsp_stall = $urandom_range(1, 18) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict from accepted requests
  always @(posedge clk) begin
    dcq_pkg::res_t exp_res;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result q=%0d pos=%0d eos=%0b",
                               rsp_if.quantized, rsp_if.position_out,
                               rsp_if.end_of_slice_out));
        end else begin
          exp_res = expected_results.pop_front();
          if (rsp_if.quantized !== exp_res.quantized ||
              rsp_if.position_out !== exp_res.pos ||
              rsp_if.end_of_slice_out !== exp_res.eos)
            flag_error($sformatf("expected q=%0d pos=%0d eos=%0b, got q=%0d pos=%0d eos=%0b",
                                 exp_res.quantized, exp_res.pos, exp_res.eos,
                                 rsp_if.quantized, rsp_if.position_out,
                                 rsp_if.end_of_slice_out));
        end
      end
      req_taken = req_if.valid && req_if.ready;
      if (req_taken) begin
        accepted++;
        if (req_if.req_type == dcq_pkg::REQ_LOAD) begin
          loads_taken++;
          weight_tab[int'(req_if.matrix_sel) % dcq_pkg::NUM_MATRICES]
                    [int'(req_if.coeff_position) % dcq_pkg::BLOCK_COEFFS] =
            req_if.weight_value;
        end else begin
          expected_results.push_back(quantized_of(req_if.matrix_sel, req_if.coeff_position,
                                                  req_if.coefficient, req_if.end_of_slice));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("dct_coefficient_quantizer_unit test failed");
        $finish;
      end
    end
  end

  // stimulus sequence and scale settings
  initial begin
    logic [dcq_pkg::SCALE_W-1:0] scale_plan [7];
    int gap_plan [7];
    int stall_plan [7];
    int ph;
    int m;
    int p;
    scale_plan = '{10'd1, 10'd512, 10'd0, 10'd1023, 10'($urandom_range(2, 511)),
                   10'($urandom_range(2, 511)), 10'd1};
    gap_plan   = '{20, 35, 10, 0, 30, 15, 0};
    stall_plan = '{25, 10, 40, 0, 20, 35, 0};

    rst_n = 1'b0;
    scale_we = 1'b0;
    scale_val = '0;
    req_if.valid = 1'b0;
    req_if.req_type = dcq_pkg::REQ_QUANT;
    req_if.matrix_sel = 1'b0;
    req_if.coeff_position = '0;
    req_if.coefficient = '0;
    req_if.weight_value = '0;
    req_if.end_of_slice = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (ph = 0; ph < 7; ph++) begin
      // first phase runs on the reset value of the scale
      if (ph > 0) begin
        @(negedge clk);
        scale_we <= 1'b1;
        scale_val <= scale_plan[ph];
        @(negedge clk);
        scale_we <= 1'b0;
        scale_now = scale_plan[ph];
      end
      @(posedge clk);
      gap_pct = gap_plan[ph];
      stall_pct = stall_plan[ph];
      if (ph == 0) begin
        // fill both matrices before any read
        for (m = 0; m < dcq_pkg::NUM_MATRICES; m++)
          for (p = 0; p < dcq_pkg::BLOCK_COEFFS; p++)
            add_load(1'(m), dcq_pkg::POS_W'(p), dcq_pkg::WT_W'($urandom_range(1, 255)));
        // smallest weight: full-scale coefficients overflow 16 bits and wrap
        add_load(1'b0, 6'd0, 8'd1);
        add_quant(1'b0, 6'd0, 16'sh7fff, 1'b0);
        add_quant(1'b0, 6'd0, 16'sh8000, 1'b0);
        add_quant(1'b0, 6'd0, -16'sd1, 1'b0);
        add_quant(1'b0, 6'd0, 16'sd0, 1'b1);
        // largest weight at the last chroma position
        add_load(1'b1, 6'd63, 8'd255);
        add_quant(1'b1, 6'd63, 16'sh7fff, 1'b0);
        add_quant(1'b1, 6'd63, 16'sh8000, 1'b0);
        add_quant(1'b1, 6'd63, 16'sd1, 1'b0);
        add_quant(1'b1, 6'd63, -16'sd1, 1'b1);
        // zero weight gives a zero quotient, then a normal weight again
        add_load(1'b0, 6'd5, 8'd0);
        add_quant(1'b0, 6'd5, 16'sd1234, 1'b0);
        add_load(1'b0, 6'd5, 8'd3);
        add_quant(1'b0, 6'd5, -16'sd7, 1'b1);
        add_quant(1'b0, 6'd1, 16'sd100, 1'b1);
        add_random_traffic(50);
      end else begin
        add_random_traffic(140);
      end
      wait (req_queue.size() == 0 && !req_if.valid && expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    if (expected_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("%0d request transactions (%0d weight loads), %0d results checked",
             accepted, loads_taken, results_checked);
    $display("scale settings 1, 512, 0, 1023, two random, 1; %0d mismatches", errors);
    if (errors == 0)
      $display("dct_coefficient_quantizer_unit test passed");
    else
      $display("dct_coefficient_quantizer_unit test failed");
    $finish;
  end

endmodule
